// ----- hw/rtl/ppmq_pkg.sv -----
package ppmq_pkg;

    // Request kinds.
    typedef enum logic [1:0] {
        K_SEND     = 2'd0,
        K_RECEIVE  = 2'd1,
        K_REGISTER = 2'd2,
        K_CLEANUP  = 2'd3
    } t_kind;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ERROR = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;    // capture the request and run the slot lookup
        logic commit;   // apply slot-table updates and issue the memory access
        logic finish;   // load the result register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic mem_read; // the committed request reads the message memory
    } t_stat;

endpackage

// ----- hw/rtl/ppmq_ctrl.sv -----
module ppmq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    output logic            o_req_ready,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    input  ppmq_pkg::t_stat i_stat,
    output ppmq_pkg::t_cmd  o_cmd
);
    import ppmq_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_LOOK, S_MEM} t_state;

    t_state r_state;
    logic   r_res_valid;
    logic   res_free;

    // The result register is free when empty or being taken this cycle.
    assign res_free    = !r_res_valid || i_res_ready;
    assign o_req_ready = (r_state == S_IDLE);
    assign o_res_valid = r_res_valid;

    always_comb begin
        o_cmd.latch  = (r_state == S_IDLE) && i_req_valid;
        o_cmd.commit = (r_state == S_LOOK);
        o_cmd.finish = ((r_state == S_LOOK) && !i_stat.mem_read && res_free) ||
                       ((r_state == S_MEM) && res_free);
    end

    // State and result-valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            if (o_cmd.finish) r_res_valid <= 1'b1;
            else if (i_res_ready) r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (i_req_valid) r_state <= S_LOOK;
                S_LOOK: begin
                    if (o_cmd.finish) r_state <= S_IDLE;
                    else r_state <= S_MEM;
                end
                S_MEM: if (res_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ----- hw/rtl/ppmq_dp.sv -----
module ppmq_dp #(
    parameter int NUM_SLOTS  = 16,
    parameter int SLOT_DEPTH = 64,
    parameter int ID_BITS    = 16,
    parameter int BODY_BITS  = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ppmq_pkg::t_cmd       i_cmd,
    output ppmq_pkg::t_stat      o_stat,
    input  logic [1:0]           i_kind,
    input  logic [ID_BITS-1:0]   i_caller,
    input  logic [ID_BITS-1:0]   i_dest,
    input  logic [BODY_BITS-1:0] i_payload,
    output logic [1:0]           o_status,
    output logic [ID_BITS-1:0]   o_sender,
    output logic [ID_BITS-1:0]   o_receiver,
    output logic [BODY_BITS-1:0] o_body
);
    import ppmq_pkg::*;

    localparam int SB = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int PB = $clog2(SLOT_DEPTH);
    localparam int CB = $clog2(SLOT_DEPTH + 1);
    localparam int AB = $clog2(NUM_SLOTS * SLOT_DEPTH);
    localparam int WB = BODY_BITS + 2 * ID_BITS;

    // Slot table.
    logic [NUM_SLOTS-1:0] r_valid;
    logic [ID_BITS-1:0]   r_owner [NUM_SLOTS];
    logic [PB-1:0]        r_head  [NUM_SLOTS];
    logic [CB-1:0]        r_count [NUM_SLOTS];
    logic [ID_BITS-1:0]   r_server;

    // Message memory: body, sender, receiver in one word.
    logic [WB-1:0] r_mem [NUM_SLOTS * SLOT_DEPTH];
    logic [WB-1:0] r_rdata;

    // Captured request and lookup results.
    logic [1:0]           r_kind;
    logic [ID_BITS-1:0]   r_caller;
    logic [ID_BITS-1:0]   r_target;
    logic [BODY_BITS-1:0] r_payload;
    logic                 r_hit, r_free_ok;
    logic [SB-1:0]        r_hit_idx, r_free_idx;
    logic                 r_mem_read;
    logic [1:0]           r_status;

    logic [ID_BITS-1:0] target, key;
    logic               hit, free_ok;
    logic [SB-1:0]      hit_idx, free_idx;

    // Route the send and pick the lookup key.
    always_comb begin
        target = (i_caller == r_server) ? i_dest : r_server;
        key    = (i_kind == K_SEND) ? target : i_caller;
    end

    // Parallel owner match and lowest free slot search.
    always_comb begin
        hit = 1'b0; hit_idx = '0; free_ok = 1'b0; free_idx = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (r_valid[i] && r_owner[i] == key) begin
                hit = 1'b1; hit_idx = SB'(i);
            end
            if (!r_valid[i]) begin
                free_ok = 1'b1; free_idx = SB'(i);
            end
        end
    end

    // Commit-stage decisions.
    logic          c_have;
    logic [SB-1:0] c_idx;
    logic [CB-1:0] c_cnt;
    logic [PB-1:0] c_head;
    logic [PB:0]   c_sum;
    logic [PB-1:0] c_wpos;
    logic [PB-1:0] c_hnext;
    logic [AB-1:0] c_addr;
    logic [1:0]    c_status;
    logic          c_write, c_read, c_claim;

    always_comb begin
        c_idx    = r_hit ? r_hit_idx : r_free_idx;
        c_have   = r_hit || r_free_ok;
        c_cnt    = r_hit ? r_count[r_hit_idx] : '0;
        c_head   = r_hit ? r_head[r_hit_idx] : '0;
        // Tail position and next head, wrapped at the queue depth.
        c_sum    = (PB+1)'(c_head) + (PB+1)'(c_cnt);
        c_wpos   = (c_sum >= (PB+1)'(SLOT_DEPTH)) ? PB'(c_sum - (PB+1)'(SLOT_DEPTH))
                                                  : PB'(c_sum);
        c_hnext  = (c_head == PB'(SLOT_DEPTH - 1)) ? '0 : c_head + 1'b1;
        c_write  = 1'b0; c_read = 1'b0; c_claim = 1'b0;
        c_status = ST_OK;
        c_addr   = AB'(c_idx) * AB'(SLOT_DEPTH) + AB'(c_head);
        case (t_kind'(r_kind))
            K_SEND: begin
                if (r_target == '0) c_status = ST_ERROR;
                else begin
                    c_claim = !r_hit && r_free_ok;
                    if (!c_have || c_cnt >= CB'(SLOT_DEPTH)) c_status = ST_ERROR;
                    else begin
                        c_write = 1'b1;
                        c_addr  = AB'(c_idx) * AB'(SLOT_DEPTH) + AB'(c_wpos);
                    end
                end
            end
            K_RECEIVE: begin
                if (!r_hit || c_cnt == '0) c_status = ST_EMPTY;
                else c_read = 1'b1;
            end
            K_REGISTER: begin
                c_claim = !r_hit && r_free_ok;
                if (!c_have) c_status = ST_ERROR;
            end
            default: c_status = ST_OK;
        endcase
    end

    assign o_stat.mem_read = c_read;

    // Slot table and server register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_server <= '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                r_owner[i] <= '0; r_head[i] <= '0; r_count[i] <= '0;
            end
        end else if (i_cmd.commit) begin
            if (c_claim) begin
                r_valid[c_idx] <= 1'b1;
                r_owner[c_idx] <= r_target;
                r_head[c_idx]  <= '0;
            end
            if (c_write) r_count[c_idx] <= c_cnt + 1'b1;
            else if (c_claim) r_count[c_idx] <= '0;
            if (c_read) begin
                r_head[c_idx]  <= c_hnext;
                r_count[c_idx] <= c_cnt - 1'b1;
            end
            if (t_kind'(r_kind) == K_REGISTER) r_server <= r_caller;
            if (t_kind'(r_kind) == K_CLEANUP) begin
                if (r_hit) begin
                    r_valid[r_hit_idx] <= 1'b0;
                    r_owner[r_hit_idx] <= '0;
                    r_head[r_hit_idx]  <= '0;
                    r_count[r_hit_idx] <= '0;
                end
                if (r_server == r_caller) r_server <= '0;
            end
        end
    end

    // Message memory, one port, registered read.
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && c_write)
            r_mem[c_addr] <= {r_target, r_caller, r_payload};
        if (i_cmd.commit && c_read)
            r_rdata <= r_mem[c_addr];
    end

    // Request capture and lookup register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_kind     <= i_kind;
            r_caller   <= i_caller;
            r_target   <= (i_kind == K_SEND) ? target : i_caller;
            r_payload  <= i_payload;
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_free_ok  <= free_ok;
            r_free_idx <= free_idx;
        end
        if (i_cmd.commit) begin
            r_mem_read <= c_read;
            r_status   <= c_status;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_cmd.commit) begin
                o_status <= c_status; o_sender <= '0; o_receiver <= '0; o_body <= '0;
            end else begin
                o_status <= r_status;
                if (r_mem_read) begin
                    o_body     <= r_rdata[BODY_BITS-1:0];
                    o_sender   <= r_rdata[BODY_BITS +: ID_BITS];
                    o_receiver <= r_rdata[BODY_BITS+ID_BITS +: ID_BITS];
                end else begin
                    o_sender <= '0; o_receiver <= '0; o_body <= '0;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/per_process_mailbox_queues_top.sv -----
// Channel | Dir | Bits of tdata, lowest first                               | tuser
// s_axis  | in  | caller_id[15:0], dest_id[31:16], payload[95:32]           | kind[1:0]
// m_axis  | out | msg_sender[15:0], msg_receiver[31:16], msg_body[95:32]    | status[1:0]
//
// One request at a time. The request is registered on acceptance and the
// result is loaded after the lookup; a receive first reads the single-port
// message memory. A new request is accepted only once the last result is
// loaded. Reset is synchronous and clears the slot table and server
// id; message memory is not cleared. A stalled result holds the block before
// it loads the following result.
module per_process_mailbox_queues_top #(
    parameter int NUM_SLOTS  = 16,
    parameter int SLOT_DEPTH = 64,
    parameter int ID_BITS    = 16,
    parameter int BODY_BITS  = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // caller_id, dest_id, payload; zero-padded to bytes
    input  logic [((2*ID_BITS+BODY_BITS+7)/8)*8-1:0] s_axis_tdata,
    // kind
    input  logic [1:0] s_axis_tuser,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // msg_sender, msg_receiver, msg_body; zero-padded to bytes
    output logic [((2*ID_BITS+BODY_BITS+7)/8)*8-1:0] m_axis_tdata,
    // status
    output logic [1:0] m_axis_tuser
);
    import ppmq_pkg::*;

    localparam int DW = ((2*ID_BITS + BODY_BITS + 7) / 8) * 8;

    t_cmd  cmd;
    t_stat stat;
    logic [1:0]           status;
    logic [ID_BITS-1:0]   sender, receiver;
    logic [BODY_BITS-1:0] body;

    ppmq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready),
        .o_res_valid(m_axis_tvalid), .i_res_ready(m_axis_tready),
        .i_stat(stat), .o_cmd(cmd)
    );

    ppmq_dp #(
        .NUM_SLOTS(NUM_SLOTS), .SLOT_DEPTH(SLOT_DEPTH),
        .ID_BITS(ID_BITS), .BODY_BITS(BODY_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_stat(stat),
        .i_kind(s_axis_tuser),
        .i_caller(s_axis_tdata[0 +: ID_BITS]),
        .i_dest(s_axis_tdata[ID_BITS +: ID_BITS]),
        .i_payload(s_axis_tdata[2*ID_BITS +: BODY_BITS]),
        .o_status(status), .o_sender(sender), .o_receiver(receiver), .o_body(body)
    );

    // Pack the result fields.
    assign m_axis_tdata = DW'({body, receiver, sender});
    assign m_axis_tuser = status;

endmodule
